// File: src/vtb_pkg.sv
// Shared types, constants and helpers for the vertex transform and bounding-box block.
package vtb_pkg;

	localparam int COORD_W    = 32;
	localparam int ANGLE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int ROT_FRAC   = 14;
	localparam int SCALE_FRAC = 16;
	localparam int AXES       = 3;
	localparam int MULS       = 4;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [1:0]                axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t SCALE_ONE = COORD_W'(64'sd1 <<< SCALE_FRAC);
	localparam angle_t ANGLE_ONE = ANGLE_W'(32'sd1 <<< ROT_FRAC);
	localparam prod_t  ROT_RND   = PROD_W'(64'sd1 <<< (ROT_FRAC - 1));
	localparam prod_t  SCL_RND   = PROD_W'(64'sd1 <<< (SCALE_FRAC - 1));

	typedef enum logic [2:0] {
		MODE_ROT_X   = 3'd0,
		MODE_ROT_Y   = 3'd1,
		MODE_ROT_Z   = 3'd2,
		MODE_SHIFT_X = 3'd3,
		MODE_SHIFT_Y = 3'd4,
		MODE_SHIFT_Z = 3'd5,
		MODE_SCALE   = 3'd6,
		MODE_BBOX    = 3'd7
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 3'd0,
		CFG_SINE   = 3'd1,
		CFG_COSINE = 3'd2,
		CFG_SHIFT  = 3'd3,
		CFG_SCALE  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_PASS  = 3'd0,
		OP_BBOX  = 3'd1,
		OP_ROT   = 3'd2,
		OP_SHIFT = 3'd3,
		OP_SCALE = 3'd4
	} op_t;

	typedef struct packed {
		mode_t  mode;
		angle_t sine;
		angle_t cosine;
		coord_t shift_amount;
		coord_t scale_factor;
	} cfg_t;

	typedef struct packed {
		op_t    op;
		axis_t  axis;
		coord_t x;
		coord_t y;
		coord_t z;
		logic   first;
	} qent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic box_valid;
		logic busy;
	} bkstat_t;

	function automatic coord_t sat_coord(input prod_t v);
		if (v > PROD_W'(COORD_MAX))
			return COORD_MAX;
		else if (v < PROD_W'(COORD_MIN))
			return COORD_MIN;
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

// File: src/vtb_vertex_if.sv
// Vertex input channel: valid/ready handshake with one vertex per item.
interface vtb_vertex_if;
	logic                                valid;
	logic                                ready;
	logic signed [vtb_pkg::COORD_W-1:0] coord_x;
	logic signed [vtb_pkg::COORD_W-1:0] coord_y;
	logic signed [vtb_pkg::COORD_W-1:0] coord_z;
	logic                                first_vertex;

	modport source (output valid, coord_x, coord_y, coord_z, first_vertex, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, first_vertex, output ready);
endinterface

// File: src/vtb_result_if.sv
// Result channel: transformed vertex plus the current bounding box.
interface vtb_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [vtb_pkg::COORD_W-1:0] out_x;
	logic signed [vtb_pkg::COORD_W-1:0] out_y;
	logic signed [vtb_pkg::COORD_W-1:0] out_z;
	logic signed [vtb_pkg::COORD_W-1:0] min_x;
	logic signed [vtb_pkg::COORD_W-1:0] max_x;
	logic signed [vtb_pkg::COORD_W-1:0] min_y;
	logic signed [vtb_pkg::COORD_W-1:0] max_y;
	logic signed [vtb_pkg::COORD_W-1:0] min_z;
	logic signed [vtb_pkg::COORD_W-1:0] max_z;

	modport source (output valid, out_x, out_y, out_z, min_x, max_x, min_y, max_y,
		min_z, max_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, min_x, max_x, min_y, max_y,
		min_z, max_z, output ready);
endinterface

// File: src/vtb_cfg_if.sv
// Configuration write channel: register index and write data.
interface vtb_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [vtb_pkg::CFG_IDX_W-1:0]      index;
	logic [vtb_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/vertex_transform_bbox.sv
// Top level of the vertex transform block with bounding-box tracking.
// Usage:
//   vertex : one signed Q16.16 vertex per item, plus first_vertex to restart the box.
//   result : transformed vertex (saturated Q16.16) and the box after that item.
//   cfg    : register writes (0 mode, 1 sine, 2 cosine, 3 shift_amount,
//            4 scale_factor); always ready, write only while no item is in flight.
// Path: an accepted item passes through the queue write, the multiply stage and the
//   round/saturate stage into the result register.
// Throughput: one item per cycle while result.ready is high; the four 32x32
//   multipliers in the back end are used once per item.
// Reset: mode bbox pass, sine 0, cosine 1.0, shift 0, scale 1.0; box cleared to
//   zero and marked empty, queue and pipeline emptied.
// Stall: while result.ready is low the result register holds; the pipeline and
//   the two-entry queue fill behind it, and vertex.ready drops once the queue is full.
module vertex_transform_bbox (
	input logic          clk,
	input logic          arst_n,
	vtb_vertex_if.sink   vertex,
	vtb_result_if.source result,
	vtb_cfg_if.sink      cfg
);
	import vtb_pkg::*;

	cfg_t    cfg_q;
	qent_t   wr_entry;
	qent_t   head;
	qstat_t  qstat;
	bkstat_t bstat;
	logic    push;
	logic    pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_BBOX;
			cfg_q.sine         <= '0;
			cfg_q.cosine       <= ANGLE_ONE;
			cfg_q.shift_amount <= '0;
			cfg_q.scale_factor <= SCALE_ONE;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_MODE:   cfg_q.mode         <= mode_t'(cfg.data[2:0]);
				CFG_SINE:   cfg_q.sine         <= cfg.data[ANGLE_W-1:0];
				CFG_COSINE: cfg_q.cosine       <= cfg.data[ANGLE_W-1:0];
				CFG_SHIFT:  cfg_q.shift_amount <= cfg.data[COORD_W-1:0];
				CFG_SCALE:  cfg_q.scale_factor <= cfg.data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	vtb_front u_front (
		.vertex (vertex),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.push   (push),
		.entry  (wr_entry)
	);

	vtb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	vtb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.cfg    (cfg_q),
		.result (result),
		.stat   (bstat)
	);

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !vertex.ready)
		else $error("vertex accepted while queue is full");

	a_empty_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!bstat.box_valid |-> (result.min_x == '0 && result.max_x == '0 &&
			result.min_y == '0 && result.max_y == '0 &&
			result.min_z == '0 && result.max_z == '0))
		else $error("box not zero before first bbox item");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.box_valid |-> (result.min_x <= result.max_x &&
			result.min_y <= result.max_y && result.min_z <= result.max_z))
		else $error("bounding box min exceeds max");

	a_result_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(bstat.busy))
		else $error("result appeared without an item in the pipeline");

endmodule

// File: src/vtb_front.sv
// Front end: accepts vertices and classifies them into an operation and an axis.
module vtb_front (
	vtb_vertex_if.sink       vertex,
	input  vtb_pkg::cfg_t    cfg,
	input  vtb_pkg::qstat_t  qstat,
	output logic             push,
	output vtb_pkg::qent_t   entry
);
	import vtb_pkg::*;

	op_t   op;
	axis_t axis;

	always_comb begin
		op   = OP_BBOX;
		axis = AXIS_X;
		case (cfg.mode)
			MODE_ROT_X: begin
				op   = OP_ROT;
				axis = AXIS_X;
			end
			MODE_ROT_Y: begin
				op   = OP_ROT;
				axis = AXIS_Y;
			end
			MODE_ROT_Z: begin
				op   = OP_ROT;
				axis = AXIS_Z;
			end
			MODE_SHIFT_X: begin
				op   = OP_SHIFT;
				axis = AXIS_X;
			end
			MODE_SHIFT_Y: begin
				op   = OP_SHIFT;
				axis = AXIS_Y;
			end
			MODE_SHIFT_Z: begin
				op   = OP_SHIFT;
				axis = AXIS_Z;
			end
			MODE_SCALE: begin
				// unity and zero factors leave the vertex untouched
				if (cfg.scale_factor == '0 || cfg.scale_factor == SCALE_ONE)
					op = OP_PASS;
				else
					op = OP_SCALE;
			end
			MODE_BBOX: op = OP_BBOX;
			default:   op = OP_BBOX;
		endcase
	end

	assign vertex.ready = !qstat.full;
	assign push         = vertex.valid && !qstat.full;

	assign entry.op    = op;
	assign entry.axis  = axis;
	assign entry.x     = vertex.coord_x;
	assign entry.y     = vertex.coord_y;
	assign entry.z     = vertex.coord_z;
	assign entry.first = vertex.first_vertex;

endmodule

// File: src/vtb_queue.sv
// Short FIFO between the front end and the arithmetic back end.
module vtb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vtb_pkg::qent_t   wr_entry,
	input  logic             pop,
	output vtb_pkg::qent_t   head,
	output vtb_pkg::qstat_t  qstat
);
	import vtb_pkg::*;

	qent_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QDEPTH - 1))
			return '0;
		else
			return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// File: src/vtb_back.sv
// Back end: multiply stage, round/saturate stage, bounding-box state and result register.
module vtb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  vtb_pkg::qent_t   head,
	input  vtb_pkg::qstat_t  qstat,
	output logic             pop,
	input  vtb_pkg::cfg_t    cfg,
	vtb_result_if.source     result,
	output vtb_pkg::bkstat_t stat
);
	import vtb_pkg::*;

	// stage 1: products and carried vertex
	logic   v_s1;
	op_t    op_s1;
	axis_t  axis_s1;
	logic   first_s1;
	coord_t crd_s1 [AXES];
	prod_t  prod_s1 [MULS];

	// stage 2: result register and box state
	logic   v_s2;
	coord_t res_s2 [AXES];
	coord_t min_q [AXES];
	coord_t max_q [AXES];
	logic   box_valid_q;

	logic   s2_free;
	logic   s1_adv;
	logic   s2_load;

	coord_t hc [AXES];
	coord_t ma [MULS];
	coord_t mb [MULS];
	prod_t  prod [MULS];

	prod_t  sum0;
	prod_t  sum1;
	prod_t  rnd0;
	prod_t  rnd1;
	coord_t rot0;
	coord_t rot1;
	prod_t  scl [AXES];
	logic signed [COORD_W:0] sh_sum;
	coord_t res [AXES];
	coord_t nmin [AXES];
	coord_t nmax [AXES];

	assign s2_free = !v_s2 || result.ready;
	assign s1_adv  = !v_s1 || s2_free;
	assign s2_load = v_s1 && s2_free;
	assign pop     = !qstat.empty && s1_adv;

	// operand steering: rotation pairs each affected axis with cosine and the other with sine
	always_comb begin
		hc[0] = head.x;
		hc[1] = head.y;
		hc[2] = head.z;
		if (head.op == OP_SCALE) begin
			ma[0] = hc[0];
			ma[1] = hc[1];
			ma[2] = hc[2];
			ma[3] = '0;
			for (int k = 0; k < MULS; k++)
				mb[k] = cfg.scale_factor;
		end else begin
			case (head.axis)
				AXIS_X: begin
					ma[0] = hc[1];
					ma[1] = hc[2];
					ma[2] = hc[2];
					ma[3] = hc[1];
				end
				AXIS_Y: begin
					ma[0] = hc[0];
					ma[1] = hc[2];
					ma[2] = hc[2];
					ma[3] = hc[0];
				end
				default: begin
					ma[0] = hc[0];
					ma[1] = hc[1];
					ma[2] = hc[1];
					ma[3] = hc[0];
				end
			endcase
			mb[0] = COORD_W'(cfg.cosine);
			mb[1] = COORD_W'(cfg.sine);
			mb[2] = COORD_W'(cfg.cosine);
			mb[3] = COORD_W'(cfg.sine);
		end
		for (int k = 0; k < MULS; k++)
			prod[k] = PROD_W'(ma[k]) * PROD_W'(mb[k]);
	end

	// round, saturate and place results
	always_comb begin
		// rotation about Y adds on the first axis and subtracts on the second
		if (axis_s1 == AXIS_Y) begin
			sum0 = prod_s1[0] + prod_s1[1];
			sum1 = prod_s1[2] - prod_s1[3];
		end else begin
			sum0 = prod_s1[0] - prod_s1[1];
			sum1 = prod_s1[2] + prod_s1[3];
		end
		rnd0 = sum0 + ROT_RND;
		rnd1 = sum1 + ROT_RND;
		rot0 = sat_coord(rnd0 >>> ROT_FRAC);
		rot1 = sat_coord(rnd1 >>> ROT_FRAC);
		for (int k = 0; k < AXES; k++)
			scl[k] = prod_s1[k] + SCL_RND;
		sh_sum = (COORD_W+1)'(crd_s1[axis_s1]) + (COORD_W+1)'(cfg.shift_amount);

		for (int k = 0; k < AXES; k++)
			res[k] = crd_s1[k];
		case (op_s1)
			OP_ROT: begin
				case (axis_s1)
					AXIS_X: begin
						res[1] = rot0;
						res[2] = rot1;
					end
					AXIS_Y: begin
						res[0] = rot0;
						res[2] = rot1;
					end
					default: begin
						res[0] = rot0;
						res[1] = rot1;
					end
				endcase
			end
			OP_SHIFT: res[axis_s1] = sat_coord(PROD_W'(sh_sum));
			OP_SCALE: begin
				for (int k = 0; k < AXES; k++)
					res[k] = sat_coord(scl[k] >>> SCALE_FRAC);
			end
			default: ;
		endcase

		for (int k = 0; k < AXES; k++) begin
			if (first_s1 || !box_valid_q) begin
				nmin[k] = crd_s1[k];
				nmax[k] = crd_s1[k];
			end else begin
				nmin[k] = (crd_s1[k] < min_q[k]) ? crd_s1[k] : min_q[k];
				nmax[k] = (crd_s1[k] > max_q[k]) ? crd_s1[k] : max_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			box_valid_q <= 1'b0;
			for (int k = 0; k < AXES; k++) begin
				min_q[k] <= '0;
				max_q[k] <= '0;
			end
		end else begin
			if (s1_adv)
				v_s1 <= !qstat.empty;
			if (s2_free)
				v_s2 <= v_s1;
			// box changes only when its item enters the result register
			if (s2_load && op_s1 == OP_BBOX) begin
				box_valid_q <= 1'b1;
				for (int k = 0; k < AXES; k++) begin
					min_q[k] <= nmin[k];
					max_q[k] <= nmax[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1    <= head.op;
			axis_s1  <= head.axis;
			first_s1 <= head.first;
			crd_s1[0] <= head.x;
			crd_s1[1] <= head.y;
			crd_s1[2] <= head.z;
			for (int k = 0; k < MULS; k++)
				prod_s1[k] <= prod[k];
		end
		if (s2_load) begin
			for (int k = 0; k < AXES; k++)
				res_s2[k] <= res[k];
		end
	end

	assign result.valid = v_s2;
	assign result.out_x = res_s2[0];
	assign result.out_y = res_s2[1];
	assign result.out_z = res_s2[2];
	assign result.min_x = min_q[0];
	assign result.max_x = max_q[0];
	assign result.min_y = min_q[1];
	assign result.max_y = max_q[1];
	assign result.min_z = min_q[2];
	assign result.max_z = max_q[2];

	assign stat.box_valid = box_valid_q;
	assign stat.busy      = v_s1 || v_s2;

endmodule

// File: dv/tb_vertex_transform_bbox.sv
// Testbench for vertex_transform_bbox: directed and random vertex streams checked against a predictor.
module tb_vertex_transform_bbox;
	import vtb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int UNIT_ANGLE     = 1 << ROT_FRAC;
	localparam int SMALL_SPAN     = 1 << 22;
	localparam int ZOOM_SPAN      = 1 << 19;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   first;
	} vertex_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		coord_t min_x;
		coord_t max_x;
		coord_t min_y;
		coord_t max_y;
		coord_t min_z;
		coord_t max_z;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	vtb_vertex_if vtx_ch();
	vtb_result_if res_ch();
	vtb_cfg_if    cfg_ch();

	vertex_transform_bbox i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vtx_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the registers and the box, at their reset values.
	mode_t  cur_mode    = MODE_BBOX;
	angle_t cur_sine    = '0;
	angle_t cur_cosine  = ANGLE_ONE;
	coord_t cur_shift   = '0;
	coord_t cur_scale   = SCALE_ONE;
	coord_t box_lo[AXES] = '{default: '0};
	coord_t box_hi[AXES] = '{default: '0};
	logic   box_started = 1'b0;

	result_t pending_results[$];
	int      fail_count     = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	int      recv_hold_left = 0;
	int      stuck_cycles   = 0;

	function automatic coord_t clamp_coord(input longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(v);
	endfunction

	// a*p + b*q with Q2.14 factors, rounded half up back to Q16.16
	function automatic coord_t rot_mix(input longint a, p, b, q);
		return clamp_coord((a * p + b * q + (64'sd1 <<< (ROT_FRAC - 1))) >>> ROT_FRAC);
	endfunction

	function automatic coord_t zoom(input longint v, f);
		return clamp_coord((v * f + (64'sd1 <<< (SCALE_FRAC - 1))) >>> SCALE_FRAC);
	endfunction

	function automatic result_t predict_vertex(input vertex_t v);
		result_t r;
		longint  inp[AXES];
		coord_t  o[AXES];
		longint  s;
		longint  c;
		int      ax;
		inp[0] = v.x;
		inp[1] = v.y;
		inp[2] = v.z;
		o[0] = v.x;
		o[1] = v.y;
		o[2] = v.z;
		s = cur_sine;
		c = cur_cosine;
		case (cur_mode)
		MODE_ROT_X: begin
			o[1] = rot_mix(inp[1], c, inp[2], -s);
			o[2] = rot_mix(inp[2], c, inp[1], s);
		end
		MODE_ROT_Y: begin
			o[0] = rot_mix(inp[0], c, inp[2], s);
			o[2] = rot_mix(inp[2], c, inp[0], -s);
		end
		MODE_ROT_Z: begin
			o[0] = rot_mix(inp[0], c, inp[1], -s);
			o[1] = rot_mix(inp[1], c, inp[0], s);
		end
		MODE_SHIFT_X, MODE_SHIFT_Y, MODE_SHIFT_Z: begin
			ax = int'(cur_mode) - int'(MODE_SHIFT_X);
			o[ax] = clamp_coord(inp[ax] + longint'(cur_shift));
		end
		MODE_SCALE: begin
			// factors of zero and one leave the vertex alone
			if (cur_scale != '0 && cur_scale != SCALE_ONE)
				for (int i = 0; i < AXES; i++)
					o[i] = zoom(inp[i], cur_scale);
		end
		MODE_BBOX: begin
			for (int i = 0; i < AXES; i++) begin
				if (v.first || !box_started) begin
					box_lo[i] = o[i];
					box_hi[i] = o[i];
				end else begin
					if (o[i] < box_lo[i])
						box_lo[i] = o[i];
					if (o[i] > box_hi[i])
						box_hi[i] = o[i];
				end
			end
			box_started = 1'b1;
		end
		default: ;
		endcase
		r.out_x = o[0];
		r.out_y = o[1];
		r.out_z = o[2];
		r.min_x = box_lo[0];
		r.max_x = box_hi[0];
		r.min_y = box_lo[1];
		r.max_y = box_hi[1];
		r.min_z = box_lo[2];
		r.max_z = box_hi[2];
		return r;
	endfunction

	function automatic void check_field(input string name, input coord_t want, got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
		0: return COORD_MAX;
		1: return COORD_MIN;
		2, 3, 4: return coord_t'($urandom);
		default: return coord_t'($urandom_range(SMALL_SPAN)) - coord_t'(SMALL_SPAN / 2);
		endcase
	endfunction

	function automatic angle_t rand_angle();
		case ($urandom_range(9))
		0: return ANGLE_ONE;
		1: return -ANGLE_ONE;
		2: return '0;
		3: return angle_t'($urandom);
		default: return angle_t'(int'($urandom_range(2 * UNIT_ANGLE)) - UNIT_ANGLE);
		endcase
	endfunction

	function automatic coord_t rand_shift();
		case ($urandom_range(9))
		0: return COORD_MAX;
		1: return COORD_MIN;
		2, 3: return coord_t'($urandom);
		default: return coord_t'($urandom_range(SMALL_SPAN)) - coord_t'(SMALL_SPAN / 2);
		endcase
	endfunction

	function automatic coord_t rand_zoom();
		case ($urandom_range(9))
		0: return '0;
		1: return SCALE_ONE;
		2: return COORD_MAX;
		3: return COORD_MIN;
		4: return coord_t'($urandom);
		default: return coord_t'($urandom_range(ZOOM_SPAN)) - coord_t'(ZOOM_SPAN / 2);
		endcase
	endfunction

	// Drop valid and wait until every predicted result has come back.
	task automatic wait_drained();
		vtx_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
		CFG_MODE:   cur_mode   = mode_t'(data[2:0]);
		CFG_SINE:   cur_sine   = angle_t'(data[ANGLE_W-1:0]);
		CFG_COSINE: cur_cosine = angle_t'(data[ANGLE_W-1:0]);
		CFG_SHIFT:  cur_shift  = coord_t'(data);
		CFG_SCALE:  cur_scale  = coord_t'(data);
		default: ;  // unused indexes change nothing
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_vertex(input coord_t x, y, z, input logic first);
		vertex_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vtx_ch.valid        <= 1'b1;
		vtx_ch.coord_x      <= x;
		vtx_ch.coord_y      <= y;
		vtx_ch.coord_z      <= z;
		vtx_ch.first_vertex <= first;
		@(posedge clk);
		while (!vtx_ch.ready)
			@(posedge clk);
		v = '{x, y, z, first};
		pending_results.insert(pending_results.size(), predict_vertex(v));
	endtask

	// Registers still at reset values; the box reads zero until bbox mode starts it.
	task automatic test_reset_defaults();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_SHIFT_X));
		send_vertex(32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000, 1'b1);
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_ROT_Z));
		send_vertex(COORD_MAX, COORD_MIN, 32'sh0000_0001, 1'b0);
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_SCALE));
		send_vertex(COORD_MIN, COORD_MAX, -32'sh0000_0001, 1'b0);
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_BBOX));
		send_vertex(32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000, 1'b0);
		send_vertex(-32'sh0005_0000, 32'sh0007_0000, '0, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 1'b1);
	endtask

	task automatic test_rotation();
		write_reg(CFG_SINE, CFG_DATA_W'(ANGLE_ONE));
		write_reg(CFG_COSINE, CFG_DATA_W'(ANGLE_ONE));
		for (int a = 0; a < AXES; a++) begin
			write_reg(CFG_MODE, CFG_DATA_W'(int'(MODE_ROT_X) + a));
			send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
			send_vertex(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_2001, 1'b0);
		end
		// sine beyond the Q2.14 unit range is used as given
		write_reg(CFG_SINE, CFG_DATA_W'({1'b1, {(ANGLE_W-1){1'b0}}}));
		write_reg(CFG_COSINE, CFG_DATA_W'(-ANGLE_ONE));
		for (int a = 0; a < AXES; a++) begin
			write_reg(CFG_MODE, CFG_DATA_W'(int'(MODE_ROT_X) + a));
			send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
		end
	endtask

	task automatic test_shift();
		write_reg(CFG_SHIFT, CFG_DATA_W'(COORD_MAX));
		for (int a = 0; a < AXES; a++) begin
			write_reg(CFG_MODE, CFG_DATA_W'(int'(MODE_SHIFT_X) + a));
			send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		end
		write_reg(CFG_SHIFT, CFG_DATA_W'(COORD_MIN));
		for (int a = 0; a < AXES; a++) begin
			write_reg(CFG_MODE, CFG_DATA_W'(int'(MODE_SHIFT_X) + a));
			send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		end
	endtask

	task automatic test_scale();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_SCALE));
		write_reg(CFG_SCALE, '0);
		send_vertex(COORD_MAX, COORD_MIN, 32'sh0001_2345, 1'b0);
		write_reg(CFG_SCALE, CFG_DATA_W'(COORD_MIN));
		send_vertex(COORD_MAX, COORD_MIN, 32'sh0000_0001, 1'b0);
		// halves round up
		write_reg(CFG_SCALE, '1);
		send_vertex(32'sh0000_8000, -32'sh0000_8000, 32'sh0001_0000, 1'b0);
		write_reg(CFG_SCALE, CFG_DATA_W'(COORD_MAX));
		send_vertex(COORD_MAX, COORD_MIN, 32'sh0001_0000, 1'b0);
		for (int i = int'(CFG_SCALE) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), '1);
		send_vertex(32'sh0000_0003, -32'sh0000_0003, COORD_MIN, 1'b1);
	endtask

	// Stall the result side long enough to fill the block, then pause the sender until empty.
	task automatic test_backpressure();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_BBOX));
		recv_hold_left = HOLD_CYCLES;
		for (int n = 0; n < 40; n++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
		wait_drained();
		for (int n = 0; n < 20; n++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
	endtask

	task automatic test_random_stream();
		int send_pct[4]  = '{0, 50, 0, 35};
		int stall_pct[4] = '{0, 0, 50, 35};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int rnd = 0; rnd < 8; rnd++) begin
				write_reg(CFG_MODE, CFG_DATA_W'((rnd + 3 * ph) % 8));
				write_reg(CFG_SINE, CFG_DATA_W'(rand_angle()));
				write_reg(CFG_COSINE, CFG_DATA_W'(rand_angle()));
				write_reg(CFG_SHIFT, CFG_DATA_W'(rand_shift()));
				write_reg(CFG_SCALE, CFG_DATA_W'(rand_zoom()));
				// box runs: an occasional restart, mostly widening
				for (int n = 0; n < 24; n++)
					send_vertex(rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(11) == 0);
			end
		end
	endtask

	// Result side: check each accepted item, then pick next cycle's ready.
	initial begin
		result_t want;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result item with no vertex pending");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("out_x", want.out_x, res_ch.out_x);
					check_field("out_y", want.out_y, res_ch.out_y);
					check_field("out_z", want.out_z, res_ch.out_z);
					check_field("min_x", want.min_x, res_ch.min_x);
					check_field("max_x", want.max_x, res_ch.max_x);
					check_field("min_y", want.min_y, res_ch.min_y);
					check_field("max_y", want.max_y, res_ch.max_y);
					check_field("min_z", want.min_z, res_ch.min_z);
					check_field("max_z", want.max_z, res_ch.max_z);
				end
			end
			if (recv_hold_left > 0) begin
				res_ch.ready <= 1'b0;
				recv_hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		arst_n              = 1'b0;
		vtx_ch.valid        = 1'b0;
		vtx_ch.coord_x      = '0;
		vtx_ch.coord_y      = '0;
		vtx_ch.coord_z      = '0;
		vtx_ch.first_vertex = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_rotation();
		test_shift();
		test_scale();
		test_backpressure();
		test_random_stream();
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: vertex_transform_bbox.f
src/vtb_pkg.sv
src/vtb_vertex_if.sv
src/vtb_result_if.sv
src/vtb_cfg_if.sv
src/vtb_front.sv
src/vtb_queue.sv
src/vtb_back.sv
src/vertex_transform_bbox.sv
dv/tb_vertex_transform_bbox.sv
